/* rtl/lggm_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes and types for the local grid to global map merge
package lggm_pkg;

  localparam int GLOBAL_SIZE = 256;
  localparam int LOCAL_MAX   = 256;
  localparam int MAP_CELLS   = GLOBAL_SIZE * GLOBAL_SIZE;
  localparam int MAP_AW      = $clog2(MAP_CELLS);
  localparam int COST_W      = 8;

  localparam logic [COST_W-1:0] UNKNOWN_COST = 8'hFF;

  localparam logic [1:0] CMD_CELL   = 2'd0;
  localparam logic [1:0] CMD_COMMIT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] REG_POSE_X   = 3'd0;
  localparam logic [2:0] REG_POSE_Y   = 3'd1;
  localparam logic [2:0] REG_COS      = 3'd2;
  localparam logic [2:0] REG_SIN      = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_OFFSET   = 3'd6;

  typedef struct packed {
    logic signed [16:0] pose_x;
    logic signed [16:0] pose_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic [8:0]         local_width;
    logic [8:0]         local_height;
    logic [7:0]         grid_offset;
  } xform_cfg_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
    logic [COST_W-1:0] cost;
  } scr_wr_t;

  typedef struct packed {
    logic idle;
    logic clearing;
    logic commit_done;
  } map_stat_t;

endpackage

/* rtl/local_grid_to_global_merge.sv */
`timescale 1ns / 1ps
// local cells go through a 3 stage transform and are then written into scratch
// cells: one transfer per cycle while in_tready is high; reads stall input until answered
// commit: drains the transform, then sweeps MAP_CELLS entries one per cycle
// the single write port of each map memory sets the sweep length
// reset (rst_n low, synchronous): both maps are then cleared over all MAP_CELLS entries, in_tready
// low meanwhile; registers return to their reset values at once
module local_grid_to_global_merge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cell_col, cell_row, cell_cost, map_x, map_y
  input  logic [1:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_cost
  output logic [0:0]  out_tuser,  // commit_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lggm_pkg::*;

  xform_cfg_t        cfg_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  logic [1:0]        cmd;
  logic [7:0]        cell_col;
  logic [7:0]        cell_row;
  logic [7:0]        cell_cost;
  logic [7:0]        map_x;
  logic [7:0]        map_y;
  logic              in_xfer;
  logic              cell_go;
  logic              commit_go;
  logic              read_go;
  logic              read_oob;
  logic [MAP_AW-1:0] read_addr;

  scr_wr_t           cell_wr;
  logic              xform_busy;
  map_stat_t         map_st;
  logic [COST_W-1:0] rd_q;

  logic              pend_valid_r;
  logic              pend_commit_r;
  logic              pend_oob_r;
  logic [COST_W-1:0] pend_cost;
  logic              pend_move;

  logic              out_valid_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_done_r;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pose_x       <= '0;
      cfg_r.pose_y       <= '0;
      cfg_r.heading_cos  <= 16'sd16384;
      cfg_r.heading_sin  <= '0;
      cfg_r.local_width  <= 9'd256;
      cfg_r.local_height <= 9'd256;
      cfg_r.grid_offset  <= 8'd128;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POSE_X: cfg_r.pose_x       <= cfg_pwdata[16:0];
        REG_POSE_Y: cfg_r.pose_y       <= cfg_pwdata[16:0];
        REG_COS:    cfg_r.heading_cos  <= cfg_pwdata[15:0];
        REG_SIN:    cfg_r.heading_sin  <= cfg_pwdata[15:0];
        REG_WIDTH:  cfg_r.local_width  <= cfg_pwdata[8:0];
        REG_HEIGHT: cfg_r.local_height <= cfg_pwdata[8:0];
        REG_OFFSET: cfg_r.grid_offset  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_POSE_X: cfg_prdata = {15'b0, cfg_r.pose_x};
      REG_POSE_Y: cfg_prdata = {15'b0, cfg_r.pose_y};
      REG_COS:    cfg_prdata = {16'b0, cfg_r.heading_cos};
      REG_SIN:    cfg_prdata = {16'b0, cfg_r.heading_sin};
      REG_WIDTH:  cfg_prdata = {23'b0, cfg_r.local_width};
      REG_HEIGHT: cfg_prdata = {23'b0, cfg_r.local_height};
      REG_OFFSET: cfg_prdata = {24'b0, cfg_r.grid_offset};
      default:    cfg_prdata = '0;
    endcase
  end

  // input decode
  assign cmd       = in_tuser;
  assign cell_col  = in_tdata[7:0];
  assign cell_row  = in_tdata[15:8];
  assign cell_cost = in_tdata[23:16];
  assign map_x     = in_tdata[31:24];
  assign map_y     = in_tdata[39:32];

  assign in_tready = map_st.idle && !pend_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign cell_go   = in_xfer && (cmd == CMD_CELL);
  assign commit_go = in_xfer && (cmd == CMD_COMMIT);
  assign read_go   = in_xfer && (cmd == CMD_READ);
  assign read_oob  = (int'(map_x) >= GLOBAL_SIZE) || (int'(map_y) >= GLOBAL_SIZE);
  assign read_addr = MAP_AW'(int'(map_y) * GLOBAL_SIZE + int'(map_x));

  lggm_xform u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_go),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .cell_cost  (cell_cost),
    .cfg        (cfg_r),
    .wr         (cell_wr),
    .busy       (xform_busy)
  );

  lggm_maps u_maps (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_wr      (cell_wr),
    .xform_busy   (xform_busy),
    .commit_start (commit_go),
    .rd_en        (read_go),
    .rd_addr      (read_addr),
    .rd_q         (rd_q),
    .stat         (map_st)
  );

  // pending result holds the memory read data or the commit answer until the output register frees
  assign pend_move = pend_valid_r && (!out_valid_r || out_tready);
  assign pend_cost = pend_commit_r ? '0 : (pend_oob_r ? UNKNOWN_COST : rd_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (read_go || map_st.commit_done) begin
      pend_valid_r <= 1'b1;
    end else if (pend_move) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_go) begin
      pend_commit_r <= 1'b0;
      pend_oob_r    <= read_oob;
    end else if (map_st.commit_done) begin
      pend_commit_r <= 1'b1;
      pend_oob_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_cost_r <= pend_cost;
      out_done_r <= pend_commit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cost_r;
  assign out_tuser  = out_done_r;

`ifndef NO_ASSERTIONS
  a_commit_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> !in_tready)
    else $error("input taken right after a commit transfer");

  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    map_st.commit_done |-> !pend_valid_r && !read_go)
    else $error("commit finished while the pending slot was busy");

  a_no_cell_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    map_st.clearing |-> !cell_wr.en && !xform_busy)
    else $error("cell write during the clearing pass");

  a_commit_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_cost_r == '0)
    else $error("commit answer carries a nonzero cost");
`endif

endmodule

/* rtl/lggm_xform.sv */
`timescale 1ns / 1ps
// three stage pipeline mapping a local cell to a scratch map write
module lggm_xform (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cell_valid,
  input  logic [7:0]                cell_col,
  input  logic [7:0]                cell_row,
  input  logic [7:0]                cell_cost,
  input  lggm_pkg::xform_cfg_t      cfg,
  output lggm_pkg::scr_wr_t         wr,
  output logic                      busy
);
  import lggm_pkg::*;

  logic [8:0]         w_lim;
  logic [8:0]         h_lim;
  logic               in_grid;
  logic signed [17:0] cx;
  logic signed [17:0] cy;

  logic               v1_r;
  logic signed [33:0] p_cc_r;
  logic signed [33:0] p_sy_r;
  logic signed [33:0] p_sx_r;
  logic signed [33:0] p_cy_r;
  logic [7:0]         cost1_r;

  logic               v2_r;
  logic signed [35:0] gx_r;
  logic signed [35:0] gy_r;
  logic [7:0]         cost2_r;
  logic signed [35:0] gx_nxt;
  logic signed [35:0] gy_nxt;
  logic signed [35:0] pose_x_q;
  logic signed [35:0] pose_y_q;
  logic signed [35:0] base_q;

  logic signed [35:0] gx_adj;
  logic signed [35:0] gy_adj;
  logic signed [13:0] rx;
  logic signed [13:0] ry;
  logic               in_map;
  logic [MAP_AW-1:0]  addr_nxt;

  logic               v3_r;
  logic [MAP_AW-1:0]  addr_r;
  logic [7:0]         cost3_r;

  // stage 0: clamp the local size, center the cell in Q.8
  always_comb begin
    w_lim   = (int'(cfg.local_width) > LOCAL_MAX) ? 9'(LOCAL_MAX) : cfg.local_width;
    h_lim   = (int'(cfg.local_height) > LOCAL_MAX) ? 9'(LOCAL_MAX) : cfg.local_height;
    in_grid = ({1'b0, cell_col} < w_lim) && ({1'b0, cell_row} < h_lim);
    cx      = $signed({2'b00, cell_col, 8'h00}) - $signed({2'b00, w_lim, 7'h00});
    cy      = $signed({2'b00, cell_row, 8'h00}) - $signed({2'b00, h_lim, 7'h00});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= cell_valid && in_grid;
    end
  end

  always_ff @(posedge clk) begin
    p_cc_r  <= 34'(cfg.heading_cos * cx);
    p_sy_r  <= 34'(cfg.heading_sin * cy);
    p_sx_r  <= 34'(cfg.heading_sin * cx);
    p_cy_r  <= 34'(cfg.heading_cos * cy);
    cost1_r <= cell_cost;
  end

  // stage 2: rotate and translate in Q.22
  always_comb begin
    pose_x_q = 36'(cfg.pose_x) <<< 14;
    pose_y_q = 36'(cfg.pose_y) <<< 14;
    base_q   = $signed({6'b0, cfg.grid_offset, 22'b0});
    gx_nxt   = 36'(p_cc_r) - 36'(p_sy_r) + pose_x_q + base_q;
    gy_nxt   = 36'(p_sx_r) + 36'(p_cy_r) + pose_y_q + base_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    gx_r    <= gx_nxt;
    gy_r    <= gy_nxt;
    cost2_r <= cost1_r;
  end

  // stage 3: round half away from zero, range check, form the address
  always_comb begin
    gx_adj   = gx_r + $signed(36'h1FFFFF) + $signed({35'b0, ~gx_r[35]});
    gy_adj   = gy_r + $signed(36'h1FFFFF) + $signed({35'b0, ~gy_r[35]});
    rx       = gx_adj[35:22];
    ry       = gy_adj[35:22];
    in_map   = !rx[13] && !ry[13] &&
               (int'(rx[12:0]) < GLOBAL_SIZE) && (int'(ry[12:0]) < GLOBAL_SIZE);
    addr_nxt = MAP_AW'(int'(ry[12:0]) * GLOBAL_SIZE + int'(rx[12:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r && in_map;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    cost3_r <= cost2_r;
  end

  assign wr.en   = v3_r;
  assign wr.addr = addr_r;
  assign wr.cost = cost3_r;
  assign busy    = v1_r || v2_r || v3_r;

endmodule

/* rtl/lggm_maps.sv */
`timescale 1ns / 1ps
// global and scratch map memories with the clear and commit sweeps
module lggm_maps (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lggm_pkg::scr_wr_t             cell_wr,
  input  logic                          xform_busy,
  input  logic                          commit_start,
  input  logic                          rd_en,
  input  logic [lggm_pkg::MAP_AW-1:0]   rd_addr,
  output logic [lggm_pkg::COST_W-1:0]   rd_q,
  output lggm_pkg::map_stat_t           stat
);
  import lggm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [COST_W-1:0] scratch_mem [MAP_CELLS];
  logic [COST_W-1:0] global_mem  [MAP_CELLS];

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [MAP_AW-1:0] cur_r;
  logic [MAP_AW-1:0] cur_nxt;
  logic              p_valid_r;
  logic [MAP_AW-1:0] p_addr_r;
  logic [COST_W-1:0] sc_q;
  logic              last;

  logic              sc_we;
  logic [MAP_AW-1:0] sc_addr;
  logic [COST_W-1:0] sc_din;
  logic              gl_we;
  logic [MAP_AW-1:0] gl_addr;
  logic [COST_W-1:0] gl_din;

  assign last = (cur_r == MAP_AW'(MAP_CELLS - 1));

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    unique case (state_r)
      ST_CLEAR: begin
        cur_nxt = last ? '0 : cur_r + 1'b1;
        if (last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (commit_start) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!xform_busy) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cur_nxt = last ? '0 : cur_r + 1'b1;
        if (last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cur_r     <= '0;
      p_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      p_valid_r <= (state_r == ST_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r <= cur_r;
  end

  // write port selection
  always_comb begin
    if (state_r == ST_CLEAR || state_r == ST_SWEEP) begin
      sc_we   = 1'b1;
      sc_addr = cur_r;
      sc_din  = UNKNOWN_COST;
    end else begin
      sc_we   = cell_wr.en;
      sc_addr = cell_wr.addr;
      sc_din  = cell_wr.cost;
    end
    if (state_r == ST_CLEAR) begin
      gl_we   = 1'b1;
      gl_addr = cur_r;
      gl_din  = UNKNOWN_COST;
    end else begin
      gl_we   = p_valid_r && (sc_q != UNKNOWN_COST);
      gl_addr = p_addr_r;
      gl_din  = sc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      scratch_mem[sc_addr] <= sc_din;
    end
    if (state_r == ST_SWEEP) begin
      sc_q <= scratch_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (gl_we) begin
      global_mem[gl_addr] <= gl_din;
    end
    if (rd_en) begin
      rd_q <= global_mem[rd_addr];
    end
  end

  assign stat.idle        = (state_r == ST_IDLE);
  assign stat.clearing    = (state_r == ST_CLEAR);
  assign stat.commit_done = (state_r == ST_FLUSH);

endmodule
